// File: sv/mqtt_rpp_pkg.sv
// Shared types, codes and constants of the MQTT received packet parser.
package mqtt_rpp_pkg;

    localparam logic [2:0] MAX_LENGTH_BYTES = 3'd4;

    localparam logic [3:0] TYPE_PUBLISH = 4'd3;
    localparam logic [3:0] TYPE_ID_LO   = 4'd4;
    localparam logic [3:0] TYPE_ID_HI   = 4'd11;

    localparam logic [2:0] KIND_HEADER     = 3'd0;
    localparam logic [2:0] KIND_LENGTH     = 3'd1;
    localparam logic [2:0] KIND_TOPIC_LEN  = 3'd2;
    localparam logic [2:0] KIND_TOPIC      = 3'd3;
    localparam logic [2:0] KIND_MESSAGE_ID = 3'd4;
    localparam logic [2:0] KIND_BODY       = 3'd5;

    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 4;

    typedef enum logic [5:0] {
        PH_HDR   = 6'b000001,
        PH_LEN   = 6'b000010,
        PH_TLEN  = 6'b000100,
        PH_TOPIC = 6'b001000,
        PH_ID    = 6'b010000,
        PH_BODY  = 6'b100000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  type_nib;
        logic [1:0]  qos;
        logic [27:0] length_accum;
        logic [2:0]  length_count;
        logic [27:0] bytes_left;
        logic [15:0] tpc_len;
        logic [15:0] field_count;
        logic [15:0] msg_id;
    } t_state;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [2:0]  byte_kind;
        logic [3:0]  packet_type;
        logic [1:0]  qos_level;
        logic [15:0] topic_length;
        logic [15:0] packet_id;
        logic [27:0] payload_length;
        logic        packet_end;
        logic        malformed;
    } t_result;

    // Byte kind reported for a byte taken in one of the body phases.
    function automatic logic [2:0] kind_of(input t_phase ph);
        logic [2:0] k;
        unique case (ph)
            PH_TLEN:  k = KIND_TOPIC_LEN;
            PH_TOPIC: k = KIND_TOPIC;
            PH_ID:    k = KIND_MESSAGE_ID;
            PH_BODY:  k = KIND_BODY;
            PH_LEN:   k = KIND_LENGTH;
            default:  k = KIND_HEADER;
        endcase
        return k;
    endfunction

endpackage

// File: sv/mqtt_rpp_step.sv
// Next-state and result logic for one received byte of the MQTT parser.
module mqtt_rpp_step (
    input  logic                  i_restart,
    input  logic [7:0]            i_byte,
    input  mqtt_rpp_pkg::t_state  i_state,
    output mqtt_rpp_pkg::t_state  o_state,
    output mqtt_rpp_pkg::t_result o_result
);

    mqtt_rpp_pkg::t_state s;
    mqtt_rpp_pkg::t_phase np;
    logic        go_hdr;
    logic        end_pkt;
    logic        bad;
    logic [2:0]  kind;
    logic [27:0] len_part;
    logic [15:0] topic_cand;
    logic [27:0] used_chk;
    logic [27:0] used;
    logic [1:0]  id_sz;
    logic        is_pub;
    logic        has_fields;

    assign go_hdr = i_restart || !(i_state.phase == mqtt_rpp_pkg::PH_LEN
                                || i_state.phase == mqtt_rpp_pkg::PH_TLEN
                                || i_state.phase == mqtt_rpp_pkg::PH_TOPIC
                                || i_state.phase == mqtt_rpp_pkg::PH_ID
                                || i_state.phase == mqtt_rpp_pkg::PH_BODY);

    // Seven length bits per byte, least significant group first.
    always_comb begin
        unique case (i_state.length_count[1:0])
            2'd0:    len_part = {21'd0, i_byte[6:0]};
            2'd1:    len_part = {14'd0, i_byte[6:0], 7'd0};
            2'd2:    len_part = {7'd0, i_byte[6:0], 14'd0};
            default: len_part = {i_byte[6:0], 21'd0};
        endcase
    end

    assign topic_cand = i_state.tpc_len | {8'd0, i_byte};
    assign used_chk   = 28'd2 + {12'd0, topic_cand} + {26'd0, (i_state.qos != 2'd0), 1'b0};

    always_comb begin
        s       = i_state;
        np      = i_state.phase;
        end_pkt = 1'b0;
        bad     = 1'b0;
        kind    = mqtt_rpp_pkg::KIND_HEADER;
        if (go_hdr) begin
            s          = '0;
            s.type_nib = i_byte[7:4];
            s.qos      = i_byte[2:1];
            np         = mqtt_rpp_pkg::PH_LEN;
        end else if (i_state.phase == mqtt_rpp_pkg::PH_LEN) begin
            kind           = mqtt_rpp_pkg::KIND_LENGTH;
            s.length_accum = i_state.length_accum | len_part;
            s.length_count = i_state.length_count + 3'd1;
            if (i_byte[7]) begin
                if (s.length_count >= mqtt_rpp_pkg::MAX_LENGTH_BYTES) begin
                    bad     = 1'b1;
                    end_pkt = 1'b1;
                    np      = mqtt_rpp_pkg::PH_HDR;
                end
            end else begin
                s.bytes_left = s.length_accum;
                if (s.length_accum == 28'd0) begin
                    end_pkt = 1'b1;
                    np      = mqtt_rpp_pkg::PH_HDR;
                    bad     = (i_state.type_nib == mqtt_rpp_pkg::TYPE_PUBLISH);
                end else if (i_state.type_nib == mqtt_rpp_pkg::TYPE_PUBLISH) begin
                    np = mqtt_rpp_pkg::PH_TLEN;
                end else if (i_state.type_nib >= mqtt_rpp_pkg::TYPE_ID_LO
                          && i_state.type_nib <= mqtt_rpp_pkg::TYPE_ID_HI) begin
                    np = mqtt_rpp_pkg::PH_ID;
                end else begin
                    np = mqtt_rpp_pkg::PH_BODY;
                end
            end
        end else begin
            kind = mqtt_rpp_pkg::kind_of(i_state.phase);
            if (i_state.bytes_left != 28'd0) begin
                s.bytes_left = i_state.bytes_left - 28'd1;
            end
            unique case (i_state.phase)
                mqtt_rpp_pkg::PH_TLEN: begin
                    if (i_state.field_count == 16'd0) begin
                        s.tpc_len     = {i_byte, 8'd0};
                        s.field_count = 16'd1;
                    end else begin
                        s.tpc_len     = topic_cand;
                        s.field_count = 16'd0;
                        bad           = (used_chk > i_state.length_accum);
                        if (topic_cand != 16'd0) begin
                            np = mqtt_rpp_pkg::PH_TOPIC;
                        end else if (i_state.qos != 2'd0) begin
                            np = mqtt_rpp_pkg::PH_ID;
                        end else begin
                            np = mqtt_rpp_pkg::PH_BODY;
                        end
                    end
                end
                mqtt_rpp_pkg::PH_TOPIC: begin
                    s.field_count = i_state.field_count + 16'd1;
                    if (s.field_count >= i_state.tpc_len) begin
                        s.field_count = 16'd0;
                        np = (i_state.qos != 2'd0) ? mqtt_rpp_pkg::PH_ID
                                                   : mqtt_rpp_pkg::PH_BODY;
                    end
                end
                mqtt_rpp_pkg::PH_ID: begin
                    if (i_state.field_count == 16'd0) begin
                        s.msg_id      = {i_byte, 8'd0};
                        s.field_count = 16'd1;
                    end else begin
                        s.msg_id      = i_state.msg_id | {8'd0, i_byte};
                        s.field_count = 16'd2;
                        np            = mqtt_rpp_pkg::PH_BODY;
                    end
                end
                default: begin
                end
            endcase
            if (s.bytes_left == 28'd0) begin
                end_pkt = 1'b1;
                if (i_state.type_nib == mqtt_rpp_pkg::TYPE_PUBLISH
                    && np == mqtt_rpp_pkg::PH_TLEN) begin
                    bad = 1'b1;
                end
            end
        end
        s.phase = end_pkt ? mqtt_rpp_pkg::PH_HDR : np;
    end

    assign id_sz      = (s.qos != 2'd0) ? 2'd2 : 2'd0;
    assign used       = 28'd2 + {12'd0, s.tpc_len} + {26'd0, id_sz};
    assign is_pub     = (s.type_nib == mqtt_rpp_pkg::TYPE_PUBLISH);
    assign has_fields = is_pub && (np == mqtt_rpp_pkg::PH_TOPIC || np == mqtt_rpp_pkg::PH_ID
                                || np == mqtt_rpp_pkg::PH_BODY);

    always_comb begin
        o_result.data_byte      = i_byte;
        o_result.byte_kind      = kind;
        o_result.packet_type    = s.type_nib;
        o_result.qos_level      = s.qos;
        o_result.topic_length   = has_fields ? s.tpc_len : 16'd0;
        o_result.payload_length = (has_fields && s.length_accum > used)
                                  ? (s.length_accum - used) : 28'd0;
        o_result.packet_id      = (np == mqtt_rpp_pkg::PH_BODY && s.field_count == 16'd2)
                                  ? s.msg_id : 16'd0;
        o_result.packet_end     = end_pkt;
        o_result.malformed      = bad;
    end

    assign o_state = s;

endmodule

// File: sv/mqtt_received_packet_parser_unit.sv
// Top level of the MQTT received packet parser: state, output register and handshakes.
//
// Usage: received MQTT stream bytes enter on the s_axis channel, one byte per beat;
// s_axis_tdata[7:0] is the byte and s_axis_tuser[0] forces it to be parsed as a new
// fixed header. Each input beat gives exactly one result beat on m_axis, which echoes
// the byte and tags it (header, length, topic length, topic, message id, body) along
// with the packet type, QoS, topic length, message id and payload length known so far.
// m_axis_tlast marks the last byte of a packet and m_axis_tuser[3] flags a malformed one.
// The result is registered: a byte accepted at a clock edge shows on m_axis after that edge.
// Throughput is one byte per cycle unless m_axis stalls; the parse state and the output
// register are the only storage, and all per-byte work fits between them.
// s_axis_tready is high while the output register is empty or being taken, so a
// stalled receiver holds the result and back-pressures the input without losing beats.
// Reset (synchronous, active low) empties the output register and makes the next byte
// a fixed header byte.
module mqtt_received_packet_parser_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // [7:0] packet_byte
    input  logic [0:0]                            s_axis_tuser,  // [0] restart
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [7:0] data_byte, [11:8] packet_type, [13:12] qos_level, [29:14] topic_length,
    // [45:30] packet_id, [73:46] payload_length, [79:74] zero
    output logic [mqtt_rpp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [mqtt_rpp_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,  // [2:0] byte_kind, [3] malformed
    output logic                                  m_axis_tlast   // packet_end
);

    mqtt_rpp_pkg::t_state  r_state;
    mqtt_rpp_pkg::t_state  n_state;
    mqtt_rpp_pkg::t_result n_result;
    mqtt_rpp_pkg::t_result r_result;
    logic                  r_out_valid;
    logic                  in_beat;

    mqtt_rpp_step u_step (
        .i_restart (s_axis_tuser[0]),
        .i_byte    (s_axis_tdata),
        .i_state   (r_state),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= {mqtt_rpp_pkg::PH_HDR,
                            {($bits(mqtt_rpp_pkg::t_state) - 6){1'b0}}};
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_result.payload_length, r_result.packet_id,
                            r_result.topic_length, r_result.qos_level,
                            r_result.packet_type, r_result.data_byte};
    assign m_axis_tuser  = {r_result.malformed, r_result.byte_kind};
    assign m_axis_tlast  = r_result.packet_end;

    // A fixed header byte never closes a packet.
    a_header_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2:0] == mqtt_rpp_pkg::KIND_HEADER) |-> !m_axis_tlast)
        else $error("header byte marked as packet end");

    // Malformed is raised only on a packet's last byte or on the closing topic length byte.
    a_malformed_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[3]) |->
            (m_axis_tlast || m_axis_tuser[2:0] == mqtt_rpp_pkg::KIND_TOPIC_LEN))
        else $error("malformed flag on an unexpected byte");

    // Every accepted byte produces a result beat in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted byte produced no result");

    // The parse state only moves on an accepted beat.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(s_axis_tvalid && s_axis_tready) && $past(i_rst_n)) |=> $stable(r_state))
        else $error("parse state changed without an input beat");

endmodule
